// ----- src/tcfc_pkg.sv -----
// ----------------------------------------------------------------------------
// tcfc_pkg
// Shared types, codes and the command decode for the command frequency
// counter.
// ----------------------------------------------------------------------------
package tcfc_pkg;

    localparam int NUM_CLASSES     = 17;
    localparam int CLASS_W         = 5;
    localparam int DATA_W          = 8;
    localparam int OUT_W           = 32;
    localparam int FIXED_W         = 2;
    localparam int COUNT_WIDTH_DEF = 32;

    typedef logic [CLASS_W-1:0] t_class;
    typedef logic [DATA_W-1:0]  t_byte;
    typedef logic [FIXED_W-1:0] t_fixed;

    localparam t_class CLS_DEV      = 5'd0;
    localparam t_class CLS_COMMENT  = 5'd1;
    localparam t_class CLS_ENDLINE  = 5'd2;
    localparam t_class CLS_PAGE     = 5'd3;
    localparam t_class CLS_RELV     = 5'd4;
    localparam t_class CLS_ABSV     = 5'd5;
    localparam t_class CLS_WORD     = 5'd6;
    localparam t_class CLS_RELH     = 5'd7;
    localparam t_class CLS_ABSH     = 5'd8;
    localparam t_class CLS_FONT     = 5'd9;
    localparam t_class CLS_PSIZE    = 5'd10;
    localparam t_class CLS_DRAW     = 5'd11;
    localparam t_class CLS_TEXT     = 5'd12;
    localparam t_class CLS_TWOCHAR  = 5'd13;
    localparam t_class CLS_ONECHAR  = 5'd14;
    localparam t_class CLS_TWONCHAR = 5'd15;
    localparam t_class CLS_WSPACE   = 5'd16;

    localparam t_byte CH_NUL   = 8'h00;
    localparam t_byte CH_NL    = 8'h0A;
    localparam t_byte CH_SP    = 8'h20;
    localparam t_byte CH_HASH  = 8'h23;
    localparam t_byte CH_ZERO  = 8'h30;
    localparam t_byte CH_NINE  = 8'h39;
    localparam t_byte CH_UC_C  = 8'h43;
    localparam t_byte CH_UC_D  = 8'h44;
    localparam t_byte CH_UC_H  = 8'h48;
    localparam t_byte CH_UC_V  = 8'h56;
    localparam t_byte CH_LC_C  = 8'h63;
    localparam t_byte CH_LC_F  = 8'h66;
    localparam t_byte CH_LC_H  = 8'h68;
    localparam t_byte CH_LC_N  = 8'h6E;
    localparam t_byte CH_LC_P  = 8'h70;
    localparam t_byte CH_LC_S  = 8'h73;
    localparam t_byte CH_LC_T  = 8'h74;
    localparam t_byte CH_LC_V  = 8'h76;
    localparam t_byte CH_LC_W  = 8'h77;
    localparam t_byte CH_LC_X  = 8'h78;

    localparam t_fixed FIXED_TWO = 2'd2;
    localparam t_fixed FIXED_ONE = 2'd1;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_FIXED,
        MODE_TO_SPACE,
        MODE_TO_NL,
        MODE_SPACES,
        MODE_DIGITS
    } t_mode;

    typedef struct packed {
        logic   hit;
        t_class cls;
        t_mode  mode;
        logic   set_fixed;
        t_fixed fixed;
    } t_start;

    typedef struct packed {
        logic   add_en;
        logic   occ_en;
        t_class cls;
    } t_update;

    function automatic logic is_digit(input t_byte c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic t_start start_of(input t_byte c);
        t_start s;
        s           = '0;
        s.hit       = 1'b1;
        s.mode      = MODE_IDLE;
        if (c == CH_NL || c == CH_SP || c == CH_NUL) begin
            s.cls = CLS_WSPACE;
        end else if (is_digit(c)) begin
            s.cls       = CLS_TWONCHAR;
            s.mode      = MODE_FIXED;
            s.set_fixed = 1'b1;
            s.fixed     = FIXED_TWO;
        end else begin
            unique case (c)
                CH_LC_C: begin
                    s.cls       = CLS_ONECHAR;
                    s.mode      = MODE_FIXED;
                    s.set_fixed = 1'b1;
                    s.fixed     = FIXED_ONE;
                end
                CH_UC_C: begin s.cls = CLS_TWOCHAR; s.mode = MODE_TO_SPACE; end
                CH_LC_F: begin s.cls = CLS_FONT;    s.mode = MODE_TO_SPACE; end
                CH_LC_T: begin s.cls = CLS_TEXT;    s.mode = MODE_TO_NL;    end
                CH_UC_D: begin s.cls = CLS_DRAW;    s.mode = MODE_TO_NL;    end
                CH_LC_N: begin s.cls = CLS_ENDLINE; s.mode = MODE_TO_NL;    end
                CH_HASH: begin s.cls = CLS_COMMENT; s.mode = MODE_TO_NL;    end
                CH_LC_X: begin s.cls = CLS_DEV;     s.mode = MODE_TO_NL;    end
                CH_LC_S: begin s.cls = CLS_PSIZE;   s.mode = MODE_SPACES;   end
                CH_UC_H: begin s.cls = CLS_ABSH;    s.mode = MODE_SPACES;   end
                CH_LC_H: begin s.cls = CLS_RELH;    s.mode = MODE_SPACES;   end
                CH_UC_V: begin s.cls = CLS_ABSV;    s.mode = MODE_SPACES;   end
                CH_LC_V: begin s.cls = CLS_RELV;    s.mode = MODE_SPACES;   end
                CH_LC_P: begin s.cls = CLS_PAGE;    s.mode = MODE_SPACES;   end
                CH_LC_W: begin s.cls = CLS_WORD;    s.mode = MODE_IDLE;     end
                default: s.hit = 1'b0;
            endcase
        end
        return s;
    endfunction

endpackage

// ----- src/tcfc_scanner.sv -----
// ----------------------------------------------------------------------------
// tcfc_scanner
// Command parser: tracks the argument rule of the open command and names
// the class that each stream byte is charged to.
// ----------------------------------------------------------------------------
module tcfc_scanner (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  tcfc_pkg::t_byte   i_byte,
    output tcfc_pkg::t_update o_upd
);
    import tcfc_pkg::*;

    t_mode   r_mode;
    t_mode   n_mode;
    t_fixed  r_fixed_left;
    t_fixed  n_fixed_left;
    t_class  r_open_class;
    t_class  n_open_class;
    t_start  st;
    t_class  k;
    logic    restart;
    logic    is_sp;
    logic    is_nl;
    logic    is_dig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_fixed_left <= '0;
            r_open_class <= '0;
        end else begin
            r_mode       <= n_mode;
            r_fixed_left <= n_fixed_left;
            r_open_class <= n_open_class;
        end
    end

    always_comb begin
        n_mode       = r_mode;
        n_fixed_left = r_fixed_left;
        n_open_class = r_open_class;
        o_upd        = '0;
        restart      = 1'b0;
        st           = start_of(i_byte);
        is_sp        = (i_byte == CH_SP);
        is_nl        = (i_byte == CH_NL);
        is_dig       = is_digit(i_byte);
        k            = (r_open_class < CLASS_W'(NUM_CLASSES)) ? r_open_class : CLS_WSPACE;
        if (i_step) begin
            unique case (r_mode)
                MODE_FIXED: begin
                    o_upd.add_en = 1'b1;
                    o_upd.cls    = k;
                    if (r_fixed_left > FIXED_ONE) begin
                        n_fixed_left = r_fixed_left - FIXED_ONE;
                    end else begin
                        n_fixed_left = '0;
                        n_mode       = MODE_IDLE;
                    end
                end
                MODE_TO_SPACE: begin
                    if (is_sp || is_nl) begin
                        restart = 1'b1;
                    end else begin
                        o_upd.add_en = 1'b1;
                        o_upd.cls    = k;
                    end
                end
                MODE_TO_NL: begin
                    o_upd.add_en = 1'b1;
                    o_upd.cls    = k;
                    if (is_nl) begin
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_SPACES: begin
                    if (is_sp) begin
                        o_upd.add_en = 1'b1;
                        o_upd.cls    = k;
                    end else if (is_dig) begin
                        o_upd.add_en = 1'b1;
                        o_upd.cls    = k;
                        n_mode       = MODE_DIGITS;
                    end else begin
                        restart = 1'b1;
                    end
                end
                MODE_DIGITS: begin
                    if (is_dig) begin
                        o_upd.add_en = 1'b1;
                        o_upd.cls    = k;
                    end else begin
                        restart = 1'b1;
                    end
                end
                default: restart = 1'b1;
            endcase
        end
        // reclassify the byte as the first byte of a new command
        if (restart) begin
            n_mode = MODE_IDLE;
            if (st.hit) begin
                o_upd.add_en = 1'b1;
                o_upd.occ_en = 1'b1;
                o_upd.cls    = st.cls;
                n_open_class = st.cls;
                n_mode       = st.mode;
                if (st.set_fixed) begin
                    n_fixed_left = st.fixed;
                end
            end
        end
    end

endmodule

// ----- src/tcfc_counter_bank.sv -----
// ----------------------------------------------------------------------------
// tcfc_counter_bank
// Per-class occurrence and byte counters with one read port.
// ----------------------------------------------------------------------------
module tcfc_counter_bank #(
    parameter int COUNT_WIDTH = tcfc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tcfc_pkg::t_update          i_upd,
    input  tcfc_pkg::t_class           i_rd_idx,
    output logic [tcfc_pkg::OUT_W-1:0] o_count,
    output logic [tcfc_pkg::OUT_W-1:0] o_bytes
);
    import tcfc_pkg::*;

    logic [COUNT_WIDTH-1:0] r_occ   [NUM_CLASSES];
    logic [COUNT_WIDTH-1:0] r_bytes [NUM_CLASSES];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_CLASSES; i++) begin
            if (!i_rst_n) begin
                r_occ[i]   <= '0;
                r_bytes[i] <= '0;
            end else if (i_upd.cls == CLASS_W'(i)) begin
                if (i_upd.occ_en) begin
                    r_occ[i] <= r_occ[i] + COUNT_WIDTH'(1);
                end
                if (i_upd.add_en) begin
                    r_bytes[i] <= r_bytes[i] + COUNT_WIDTH'(1);
                end
            end
        end
    end

    always_comb begin
        o_count = '0;
        o_bytes = '0;
        if (i_rd_idx < CLASS_W'(NUM_CLASSES)) begin
            o_count = OUT_W'(r_occ[i_rd_idx]);
            o_bytes = OUT_W'(r_bytes[i_rd_idx]);
        end
    end

endmodule

// ----- src/typeset_command_frequency_counter.sv -----
// ----------------------------------------------------------------------------
// typeset_command_frequency_counter
// Sorts typesetter command bytes into 17 classes and counts commands and
// bytes per class; a read beat returns one class's two counters.
// ----------------------------------------------------------------------------
// One beat a cycle, sustained, while no read waits on a stalled output. A
// feed beat is registered, then parsed and charged to the counters in the
// next cycle; a read beat is registered, then its counters are copied into
// the output register once that register is free. A read that follows
// feed beats directly sees their counts. A feed beat gives no result.
// Counters wrap at COUNT_WIDTH bits and the outputs carry their low 32 bits;
// a read of a class above 16 returns zeros. Counters are clear right out of reset, with no warm-up.
module typeset_command_frequency_counter #(
    parameter int COUNT_WIDTH = tcfc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_cmd,
    input  logic [tcfc_pkg::DATA_W-1:0]  i_data_byte,
    input  logic [tcfc_pkg::CLASS_W-1:0] i_class_index,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [tcfc_pkg::OUT_W-1:0]   o_class_count,
    output logic [tcfc_pkg::OUT_W-1:0]   o_class_bytes
);
    import tcfc_pkg::*;

    logic            r_s1_valid;
    logic            r_s1_cmd;
    t_byte           r_s1_byte;
    t_class          r_s1_idx;
    logic            r_out_valid;
    logic [OUT_W-1:0] r_count;
    logic [OUT_W-1:0] r_bytes;
    logic            out_free;
    logic            s1_fire;
    logic            in_take;
    t_update         upd;
    logic [OUT_W-1:0] rd_count;
    logic [OUT_W-1:0] rd_bytes;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && (!r_s1_cmd || out_free);
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_fire && r_s1_cmd) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_cmd  <= i_cmd;
            r_s1_byte <= i_data_byte;
            r_s1_idx  <= i_class_index;
        end
        if (s1_fire && r_s1_cmd) begin
            r_count <= rd_count;
            r_bytes <= rd_bytes;
        end
    end

    tcfc_scanner u_scanner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s1_fire && !r_s1_cmd),
        .i_byte  (r_s1_byte),
        .o_upd   (upd)
    );

    tcfc_counter_bank #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_bank (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_upd    (upd),
        .i_rd_idx (r_s1_idx),
        .o_count  (rd_count),
        .o_bytes  (rd_bytes)
    );

    assign o_out_valid   = r_out_valid;
    assign o_class_count = r_count;
    assign o_class_bytes = r_bytes;

endmodule

// ----- src/tcfc_checker.sv -----
// ----------------------------------------------------------------------------
// tcfc_assert
// Port-level checks for the command frequency counter, bound to the top.
// ----------------------------------------------------------------------------
module tcfc_assert (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [tcfc_pkg::OUT_W-1:0]   o_class_count,
    input logic [tcfc_pkg::OUT_W-1:0]   o_class_bytes
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_class_count) && $stable(o_class_bytes))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

    a_drain_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready |-> o_in_ready)
        else $error("input blocked while result drains");

endmodule

bind typeset_command_frequency_counter tcfc_assert u_tcfc_assert (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_class_count (o_class_count),
    .o_class_bytes (o_class_bytes)
);

// ----- tb/sv/tcfc_checker.sv -----
// ----------------------------------------------------------------------------
// tcfc_checker
// Watches the beat and result channels of the command frequency counter,
// tracks the command parse and the per-class counters on its own, and
// compares every read result, field by field, with the oldest snapshot.
// ----------------------------------------------------------------------------
module tcfc_checker
    import tcfc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_cmd,
    input  t_byte              i_data_byte,
    input  t_class             i_class_index,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [OUT_W-1:0]   i_class_count,
    input  logic [OUT_W-1:0]   i_class_bytes,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct {
        logic [OUT_W-1:0] count;
        logic [OUT_W-1:0] bytes;
    } t_tally;

    t_mode                  scan_mode;
    t_fixed                 fixed_left;
    t_class                 open_cls;
    logic [COUNT_WIDTH-1:0] cmd_count [NUM_CLASSES];
    logic [COUNT_WIDTH-1:0] byte_total [NUM_CLASSES];
    t_tally                 tally_q [$];

    function automatic logic decode_head(input t_byte c, output t_class cls,
                                         output t_mode mode, output t_fixed left);
        decode_head = 1'b1;
        cls         = CLS_WSPACE;
        mode        = MODE_IDLE;
        left        = '0;
        if (c == CH_NL || c == CH_SP || c == CH_NUL) begin
            cls = CLS_WSPACE;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            cls  = CLS_TWONCHAR;
            mode = MODE_FIXED;
            left = FIXED_TWO;
        end else begin
            case (c)
                CH_LC_C: begin cls = CLS_ONECHAR; mode = MODE_FIXED; left = FIXED_ONE; end
                CH_UC_C: begin cls = CLS_TWOCHAR; mode = MODE_TO_SPACE; end
                CH_LC_F: begin cls = CLS_FONT;    mode = MODE_TO_SPACE; end
                CH_LC_T: begin cls = CLS_TEXT;    mode = MODE_TO_NL;    end
                CH_UC_D: begin cls = CLS_DRAW;    mode = MODE_TO_NL;    end
                CH_LC_N: begin cls = CLS_ENDLINE; mode = MODE_TO_NL;    end
                CH_HASH: begin cls = CLS_COMMENT; mode = MODE_TO_NL;    end
                CH_LC_X: begin cls = CLS_DEV;     mode = MODE_TO_NL;    end
                CH_LC_S: begin cls = CLS_PSIZE;   mode = MODE_SPACES;   end
                CH_UC_H: begin cls = CLS_ABSH;    mode = MODE_SPACES;   end
                CH_LC_H: begin cls = CLS_RELH;    mode = MODE_SPACES;   end
                CH_UC_V: begin cls = CLS_ABSV;    mode = MODE_SPACES;   end
                CH_LC_V: begin cls = CLS_RELV;    mode = MODE_SPACES;   end
                CH_LC_P: begin cls = CLS_PAGE;    mode = MODE_SPACES;   end
                CH_LC_W: begin cls = CLS_WORD;    mode = MODE_IDLE;     end
                default: decode_head = 1'b0;
            endcase
        end
    endfunction

    task automatic charge_byte(input t_class k);
        byte_total[k] = byte_total[k] + 1'b1;
    endtask

    task automatic open_command(input t_byte c);
        t_class cls;
        t_mode  mode;
        t_fixed left;
        scan_mode = MODE_IDLE;
        if (decode_head(c, cls, mode, left)) begin
            cmd_count[cls] = cmd_count[cls] + 1'b1;
            charge_byte(cls);
            open_cls  = cls;
            scan_mode = mode;
            if (mode == MODE_FIXED) begin
                fixed_left = left;
            end
        end
    endtask

    task automatic parse_byte(input t_byte c);
        t_class k;
        logic   dig;
        k   = (open_cls < NUM_CLASSES) ? open_cls : CLS_WSPACE;
        dig = (c >= CH_ZERO && c <= CH_NINE);
        case (scan_mode)
            MODE_FIXED: begin
                charge_byte(k);
                if (fixed_left > 1) begin
                    fixed_left = fixed_left - 1'b1;
                end else begin
                    fixed_left = '0;
                    scan_mode  = MODE_IDLE;
                end
            end
            MODE_TO_SPACE: begin
                if (c == CH_SP || c == CH_NL) begin
                    open_command(c);
                end else begin
                    charge_byte(k);
                end
            end
            MODE_TO_NL: begin
                charge_byte(k);
                if (c == CH_NL) begin
                    scan_mode = MODE_IDLE;
                end
            end
            MODE_SPACES: begin
                if (c == CH_SP) begin
                    charge_byte(k);
                end else if (dig) begin
                    charge_byte(k);
                    scan_mode = MODE_DIGITS;
                end else begin
                    open_command(c);
                end
            end
            MODE_DIGITS: begin
                if (dig) begin
                    charge_byte(k);
                end else begin
                    open_command(c);
                end
            end
            default: open_command(c);
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                   input logic [OUT_W-1:0] want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_tally snap;
        t_tally want;
        if (!i_rst_n) begin
            scan_mode  = MODE_IDLE;
            fixed_left = '0;
            open_cls   = '0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                cmd_count[i]  = '0;
                byte_total[i] = '0;
            end
            tally_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (i_cmd) begin
                    snap.count = '0;
                    snap.bytes = '0;
                    if (i_class_index < NUM_CLASSES) begin
                        snap.count = OUT_W'(cmd_count[i_class_index]);
                        snap.bytes = OUT_W'(byte_total[i_class_index]);
                    end
                    tally_q.push_back(snap);
                end else begin
                    parse_byte(i_data_byte);
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (tally_q.size() == 0) begin
                    report_mismatch("result without a pending read", i_class_count, '0);
                end else begin
                    want = tally_q.pop_front();
                    if (i_class_count !== want.count) begin
                        report_mismatch("class_count", i_class_count, want.count);
                    end
                    if (i_class_bytes !== want.bytes) begin
                        report_mismatch("class_bytes", i_class_bytes, want.bytes);
                    end
                end
            end
        end
        o_pending = tally_q.size();
    end

endmodule

// ----- tb/sv/tb_typeset_command_frequency_counter.sv -----
// ----------------------------------------------------------------------------
// tb_typeset_command_frequency_counter
// Drives command-stream beats and class reads into the counter in random
// bursts against a stalling receiver, with one long receiver hold-off;
// the checker judges every result.
// ----------------------------------------------------------------------------
module tb_typeset_command_frequency_counter;
    import tcfc_pkg::*;

    localparam int CNT_W        = 16;
    localparam int RANDOM_BEATS = 660;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int RUN_LIMIT    = 100000;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               i_cmd         = 1'b0;
    t_byte              i_data_byte   = '0;
    t_class             i_class_index = '0;
    logic               i_out_ready   = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic [OUT_W-1:0]   o_class_count;
    logic [OUT_W-1:0]   o_class_bytes;

    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   beat_count  = 0;
    int   burst_left  = 0;
    logic hold_req    = 1'b0;
    logic hold_done   = 1'b0;

    always #5 i_clk = ~i_clk;

    typeset_command_frequency_counter #(
        .COUNT_WIDTH(CNT_W)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_data_byte  (i_data_byte),
        .i_class_index(i_class_index),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_class_count(o_class_count),
        .o_class_bytes(o_class_bytes)
    );

    tcfc_checker #(
        .COUNT_WIDTH(CNT_W)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_data_byte  (i_data_byte),
        .i_class_index(i_class_index),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_class_count(o_class_count),
        .i_class_bytes(o_class_bytes),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : ready_pattern
        int seg_left;
        int seg_mode;
        seg_left = 0;
        seg_mode = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            if (seg_left == 0) begin
                seg_mode = $urandom_range(0, 2);
                seg_left = $urandom_range(8, 64);
            end
            seg_left--;
            case (seg_mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= 1'($urandom_range(0, 1));
                default: i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send_beat(input logic cmd, input t_byte b, input t_class idx);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 200)
                                                     : $urandom_range(1, 16);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_data_byte   <= b;
        i_class_index <= idx;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        burst_left--;
        beat_count++;
    endtask

    task automatic feed_byte(input t_byte b);
        send_beat(1'b0, b, t_class'($urandom_range(0, 31)));
    endtask

    task automatic read_class(input t_class idx);
        send_beat(1'b1, t_byte'($urandom_range(0, 255)), idx);
    endtask

    function automatic t_byte plain_byte();
        t_byte b;
        do begin
            b = t_byte'($urandom_range(0, 255));
        end while (b == CH_SP || b == CH_NL);
        return b;
    endfunction

    function automatic t_byte digit_byte();
        return t_byte'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    task automatic emit_command();
        int    n;
        t_byte head;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 2))
                    0:       feed_byte(CH_NUL);
                    1:       feed_byte(CH_SP);
                    default: feed_byte(CH_NL);
                endcase
            end
            1: begin
                feed_byte(digit_byte());
                feed_byte(t_byte'($urandom_range(0, 255)));
                feed_byte(t_byte'($urandom_range(0, 255)));
            end
            2: begin
                feed_byte(CH_LC_C);
                feed_byte(t_byte'($urandom_range(0, 255)));
            end
            3: begin
                feed_byte($urandom_range(0, 1) ? CH_UC_C : CH_LC_F);
                n = $urandom_range(0, 6);
                repeat (n) feed_byte(plain_byte());
                feed_byte($urandom_range(0, 1) ? CH_SP : CH_NL);
            end
            4, 5: begin
                case ($urandom_range(0, 4))
                    0:       head = CH_LC_T;
                    1:       head = CH_UC_D;
                    2:       head = CH_LC_N;
                    3:       head = CH_HASH;
                    default: head = CH_LC_X;
                endcase
                feed_byte(head);
                n = $urandom_range(0, 8);
                repeat (n) feed_byte(plain_byte());
                feed_byte(CH_NL);
            end
            6, 7: begin
                case ($urandom_range(0, 5))
                    0:       head = CH_LC_S;
                    1:       head = CH_UC_H;
                    2:       head = CH_LC_H;
                    3:       head = CH_UC_V;
                    4:       head = CH_LC_V;
                    default: head = CH_LC_P;
                endcase
                feed_byte(head);
                n = $urandom_range(0, 3);
                repeat (n) feed_byte(CH_SP);
                n = $urandom_range(0, 4);
                repeat (n) feed_byte(digit_byte());
                if ($urandom_range(0, 3) == 0) begin
                    feed_byte(CH_SP);
                end
            end
            8:       feed_byte(CH_LC_W);
            default: feed_byte(t_byte'($urandom_range(0, 255)));
        endcase
    endtask

    initial begin : stimulus
        int n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset values, out-of-range reads, each argument rule
        read_class(CLS_DEV);
        read_class(t_class'(NUM_CLASSES));
        read_class(t_class'(31));
        feed_byte(CH_NUL);
        feed_byte(CH_SP);
        feed_byte(CH_NL);
        feed_byte(CH_LC_W);
        feed_byte(CH_NINE);
        feed_byte(8'hFF);
        feed_byte(CH_NUL);
        feed_byte(CH_LC_C);
        feed_byte(CH_NL);
        feed_byte(CH_LC_F);
        feed_byte(8'h52);
        feed_byte(CH_SP);
        feed_byte(CH_LC_S);
        feed_byte(CH_SP);
        feed_byte(CH_ZERO);
        feed_byte(CH_SP);
        feed_byte(CH_LC_X);
        feed_byte(8'h71);
        read_class(CLS_DEV);
        feed_byte(CH_NL);
        feed_byte(CH_LC_P);
        feed_byte(CH_UC_D);
        feed_byte(CH_NL);
        read_class(CLS_WSPACE);
        read_class(CLS_DRAW);

        // receiver holds off while reads keep coming
        hold_req = 1'b1;
        repeat (40) begin
            read_class(t_class'($urandom_range(0, NUM_CLASSES - 1)));
            feed_byte(t_byte'($urandom_range(0, 255)));
        end

        n = beat_count + RANDOM_BEATS;
        while (beat_count < n) begin
            if ($urandom_range(0, 99) < 15) begin
                if ($urandom_range(0, 4) == 0) begin
                    read_class(t_class'($urandom_range(0, 31)));
                end else begin
                    read_class(t_class'($urandom_range(0, NUM_CLASSES - 1)));
                end
            end else begin
                emit_command();
            end
        end

        // close any open command, then read every class
        repeat (3) feed_byte(CH_NL);
        for (n = 0; n < 32; n++) begin
            read_class(t_class'(n));
        end
        i_in_valid <= 1'b0;

        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/tcfc_pkg.sv
src/tcfc_scanner.sv
src/tcfc_counter_bank.sv
src/typeset_command_frequency_counter.sv
src/tcfc_checker.sv
tb/sv/tcfc_checker.sv
tb/sv/tb_typeset_command_frequency_counter.sv
